FILE: design/sfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared widths, coefficients and datapath control for the stereo feedback
// reverb.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int SFR_DELAY_DEPTH = 32768;

	localparam int SMP_W  = 32;
	localparam int ECHO_W = 24;
	localparam int DLY_W  = 15;
	localparam int GAIN_W = 16;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [DLY_W-1:0]  TAP_A_RESET    = DLY_W'(1278);
	localparam logic [DLY_W-1:0]  TAP_B_RESET    = DLY_W'(1631);
	localparam logic [DLY_W-1:0]  TAP_C_RESET    = DLY_W'(1808);
	localparam logic [GAIN_W-1:0] WET_GAIN_RESET = '0;

	// Q0.16 tap coefficients and the Q0.16 feedback coefficient
	localparam int COEF_W  = 16;
	localparam int FBC_W   = 15;
	localparam logic [COEF_W-1:0] COEF_A  = COEF_W'(36045);
	localparam logic [COEF_W-1:0] COEF_B  = COEF_W'(16384);
	localparam logic [COEF_W-1:0] COEF_C  = COEF_W'(13107);
	localparam logic [FBC_W-1:0]  COEF_FB = FBC_W'(29491);

	// wet accumulator, split into low and high halves for the scaling products
	localparam int ACC_W  = ECHO_W + COEF_W + 1;
	localparam int LO_W   = 20;
	localparam int HI_W   = ACC_W - LO_W;
	localparam int SUM_W  = 58;
	localparam int FB_SH  = 32;
	localparam int MIX_SH = 31;

	typedef enum logic [1:0] {
		COEF_SEL_A,
		COEF_SEL_B,
		COEF_SEL_C
	} coef_sel_t;

	typedef struct packed {
		logic      mac_en;
		logic      mac_first;
		coef_sel_t coef;
		logic      prod_en;
		logic      sum_en;
	} sfr_ctl_t;

endpackage
`default_nettype wire

FILE: design/sfr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sfr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

FILE: design/sfr_chan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_chan
// One channel datapath: tap multiply-accumulate, feedback and output scaling,
// rounding and saturation.
// ----------------------------------------------------------------------------
module sfr_chan
	import sfr_pkg::*;
(
	input  wire logic                     clk,
	input  wire sfr_ctl_t                 ctl,
	input  wire logic signed [ECHO_W-1:0] tap,
	input  wire logic        [GAIN_W-1:0] gain,
	input  wire logic signed [SMP_W-1:0]  send,
	input  wire logic signed [SMP_W-1:0]  dry,
	output logic      signed [ECHO_W-1:0] echo_wr,
	output logic      signed [SMP_W-1:0]  mix
);

	localparam int FBH_W  = HI_W + FBC_W + 1;
	localparam int FBL_W  = LO_W + FBC_W;
	localparam int GH_W   = HI_W + GAIN_W + 1;
	localparam int GL_W   = LO_W + GAIN_W;
	localparam int WIDE_W = SMP_W + 2;

	logic        [COEF_W-1:0] coef;
	logic signed [ACC_W-1:0]  mac_prod;
	logic signed [ACC_W-1:0]  acc_q;
	logic        [LO_W-1:0]   acc_lo;
	logic signed [HI_W-1:0]   acc_hi;

	logic signed [FBH_W-1:0]  fb_hi_s1;
	logic        [FBL_W-1:0]  fb_lo_s1;
	logic signed [GH_W-1:0]   g_hi_s1;
	logic        [GL_W-1:0]   g_lo_s1;

	logic signed [SUM_W-1:0]  fb_sum_q;
	logic signed [SUM_W-1:0]  g_sum_q;

	logic signed [SUM_W-FB_SH-1:0]  fb_term;
	logic signed [SUM_W-MIX_SH-1:0] g_term;
	logic signed [WIDE_W-1:0]       fb_full;
	logic signed [WIDE_W-1:0]       mix_full;

	always_comb begin
		case (ctl.coef)
			COEF_SEL_A: coef = COEF_A;
			COEF_SEL_B: coef = COEF_B;
			COEF_SEL_C: coef = COEF_C;
			default:    coef = '0;
		endcase
	end

	assign mac_prod = tap * $signed({1'b0, coef});
	assign acc_lo   = acc_q[LO_W-1:0];
	assign acc_hi   = acc_q[ACC_W-1:LO_W];

	always_ff @(posedge clk) begin
		if (ctl.mac_en) begin
			acc_q <= ctl.mac_first ? mac_prod : acc_q + mac_prod;
		end
		if (ctl.prod_en) begin
			fb_hi_s1 <= acc_hi * $signed({1'b0, COEF_FB});
			fb_lo_s1 <= acc_lo * COEF_FB;
			g_hi_s1  <= acc_hi * $signed({1'b0, gain});
			g_lo_s1  <= acc_lo * gain;
		end
		if (ctl.sum_en) begin
			fb_sum_q <= (SUM_W'(fb_hi_s1) <<< LO_W) + SUM_W'(fb_lo_s1)
				+ (SUM_W'(1) << (FB_SH - 1));
			g_sum_q  <= (SUM_W'(g_hi_s1) <<< LO_W) + SUM_W'(g_lo_s1)
				+ (SUM_W'(1) << (MIX_SH - 1));
		end
	end

	assign fb_term  = fb_sum_q[SUM_W-1:FB_SH];
	assign g_term   = g_sum_q[SUM_W-1:MIX_SH];
	assign fb_full  = WIDE_W'(send) + WIDE_W'(fb_term);
	assign mix_full = WIDE_W'(dry) + WIDE_W'(g_term);

	always_comb begin
		if ((&fb_full[WIDE_W-1:ECHO_W-1]) || (~|fb_full[WIDE_W-1:ECHO_W-1])) begin
			echo_wr = fb_full[ECHO_W-1:0];
		end else if (fb_full[WIDE_W-1]) begin
			echo_wr = {1'b1, {(ECHO_W-1){1'b0}}};
		end else begin
			echo_wr = {1'b0, {(ECHO_W-1){1'b1}}};
		end

		if ((&mix_full[WIDE_W-1:SMP_W-1]) || (~|mix_full[WIDE_W-1:SMP_W-1])) begin
			mix = mix_full[SMP_W-1:0];
		end else if (mix_full[WIDE_W-1]) begin
			mix = {1'b1, {(SMP_W-1){1'b0}}};
		end else begin
			mix = {1'b0, {(SMP_W-1){1'b1}}};
		end
	end

endmodule
`default_nettype wire

FILE: design/stereo_feedback_reverb.sv
`timescale 1ns / 1ps
`default_nettype none
// Frames: a new frame is taken only in S_IDLE, once the last one is written back;
//   the three tap reads per channel share the single read port of each delay RAM.
// Order: tap reads, then scaling, then write-back with the registered result beat.
// Reset: tap delays and gain take their defaults, write pointer goes to zero;
//   delay entries not yet written read as zero (no clearing pass needed).
// ----------------------------------------------------------------------------
// stereo_feedback_reverb
// Stereo three-tap feedback delay reverb with cross-channel tap, Q1.23 delay
// lines held in two RAMs and saturated dry plus wet output mix.
// ----------------------------------------------------------------------------
module stereo_feedback_reverb
	import sfr_pkg::*;
#(
	parameter int DELAY_DEPTH = SFR_DELAY_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// send_left, send_right, dry_left, dry_right
	input  wire logic [4*SMP_W-1:0]    s_tdata,
	// block_end
	input  wire logic                  s_tlast,

	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// mix_left, mix_right
	output logic      [2*SMP_W-1:0]    m_tdata,
	// block_end_out
	output logic                       m_tlast,

	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int PTR_W = $clog2(DELAY_DEPTH);
	localparam int EXT_W = ((PTR_W > DLY_W) ? PTR_W : DLY_W) + 1;
	localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(DELAY_DEPTH);
	localparam logic [EXT_W-1:0] DLY_MAX   = EXT_W'(DELAY_DEPTH - 1);
	localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DELAY_DEPTH - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TAP_A,
		CFG_TAP_B,
		CFG_TAP_C,
		CFG_WET_GAIN
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RA,
		S_RB,
		S_RC,
		S_MC,
		S_PR,
		S_SUM,
		S_FIN
	} state_t;

	state_t state_q;

	logic [DLY_W-1:0]  tap_a_q;
	logic [DLY_W-1:0]  tap_b_q;
	logic [DLY_W-1:0]  tap_c_q;
	logic [GAIN_W-1:0] wet_gain_q;

	logic [PTR_W-1:0]  wp_q;
	logic              full_q;

	logic signed [SMP_W-1:0] send_l_q;
	logic signed [SMP_W-1:0] send_r_q;
	logic signed [SMP_W-1:0] dry_l_q;
	logic signed [SMP_W-1:0] dry_r_q;
	logic                    last_q;

	logic [DLY_W-1:0]  dly_sel;
	logic [EXT_W-1:0]  dly_sat;
	logic [EXT_W-1:0]  diff;
	logic [PTR_W-1:0]  rd_addr;
	logic              tap_valid;
	logic              rd_valid_s1;

	logic [ECHO_W-1:0]        rd_l;
	logic [ECHO_W-1:0]        rd_r;
	logic signed [ECHO_W-1:0] tap_l;
	logic signed [ECHO_W-1:0] tap_r;
	logic signed [ECHO_W-1:0] echo_l;
	logic signed [ECHO_W-1:0] echo_r;
	logic signed [SMP_W-1:0]  mix_l;
	logic signed [SMP_W-1:0]  mix_r;

	logic     out_free;
	logic     wr_en;
	sfr_ctl_t ctl;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid || m_tready;
	assign wr_en     = (state_q == S_FIN) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_a_q    <= TAP_A_RESET;
			tap_b_q    <= TAP_B_RESET;
			tap_c_q    <= TAP_C_RESET;
			wet_gain_q <= WET_GAIN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TAP_A:    tap_a_q    <= cfg_data[DLY_W-1:0];
				CFG_TAP_B:    tap_b_q    <= cfg_data[DLY_W-1:0];
				CFG_TAP_C:    tap_c_q    <= cfg_data[DLY_W-1:0];
				CFG_WET_GAIN: wet_gain_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// tap address: write pointer minus saturated delay, wrapped into the line
	always_comb begin
		case (state_q)
			S_RB:    dly_sel = tap_b_q;
			S_RC:    dly_sel = tap_c_q;
			default: dly_sel = tap_a_q;
		endcase
		dly_sat = EXT_W'(dly_sel);
		if (dly_sat == '0) begin
			dly_sat = EXT_W'(1);
		end else if (dly_sat > DLY_MAX) begin
			dly_sat = DLY_MAX;
		end
		diff = EXT_W'(wp_q) - dly_sat;
		if (diff[EXT_W-1]) begin
			diff = diff + DEPTH_EXT;
		end
		rd_addr   = diff[PTR_W-1:0];
		tap_valid = full_q || (rd_addr < wp_q);
	end

	always_ff @(posedge clk) begin
		rd_valid_s1 <= tap_valid;
		if (s_tvalid && s_tready) begin
			send_l_q <= s_tdata[SMP_W-1:0];
			send_r_q <= s_tdata[2*SMP_W-1:SMP_W];
			dry_l_q  <= s_tdata[3*SMP_W-1:2*SMP_W];
			dry_r_q  <= s_tdata[4*SMP_W-1:3*SMP_W];
			last_q   <= s_tlast;
		end
	end

	// cross tap: left takes the right line and right the left line
	always_comb begin
		if (!rd_valid_s1) begin
			tap_l = '0;
			tap_r = '0;
		end else if (state_q == S_MC) begin
			tap_l = rd_r;
			tap_r = rd_l;
		end else begin
			tap_l = rd_l;
			tap_r = rd_r;
		end
	end

	always_comb begin
		ctl.mac_en    = (state_q == S_RB) || (state_q == S_RC) || (state_q == S_MC);
		ctl.mac_first = (state_q == S_RB);
		case (state_q)
			S_RB:    ctl.coef = COEF_SEL_A;
			S_RC:    ctl.coef = COEF_SEL_B;
			default: ctl.coef = COEF_SEL_C;
		endcase
		ctl.prod_en = (state_q == S_PR);
		ctl.sum_en  = (state_q == S_SUM);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			wp_q     <= '0;
			full_q   <= 1'b0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tlast  <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && !wr_en) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_RA;
					end
				end
				S_RA:  state_q <= S_RB;
				S_RB:  state_q <= S_RC;
				S_RC:  state_q <= S_MC;
				S_MC:  state_q <= S_PR;
				S_PR:  state_q <= S_SUM;
				S_SUM: state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {mix_r, mix_l};
						m_tlast  <= last_q;
						if (wp_q == PTR_LAST) begin
							wp_q   <= '0;
							full_q <= 1'b1;
						end else begin
							wp_q <= wp_q + PTR_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	sfr_ram #(
		.WIDTH (ECHO_W),
		.DEPTH (DELAY_DEPTH)
	) u_ram_l (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wp_q),
		.wr_data (echo_l),
		.rd_addr (rd_addr),
		.rd_data (rd_l)
	);

	sfr_ram #(
		.WIDTH (ECHO_W),
		.DEPTH (DELAY_DEPTH)
	) u_ram_r (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wp_q),
		.wr_data (echo_r),
		.rd_addr (rd_addr),
		.rd_data (rd_r)
	);

	sfr_chan u_chan_l (
		.clk     (clk),
		.ctl     (ctl),
		.tap     (tap_l),
		.gain    (wet_gain_q),
		.send    (send_l_q),
		.dry     (dry_l_q),
		.echo_wr (echo_l),
		.mix     (mix_l)
	);

	sfr_chan u_chan_r (
		.clk     (clk),
		.ctl     (ctl),
		.tap     (tap_r),
		.gain    (wet_gain_q),
		.send    (send_r_q),
		.dry     (dry_r_q),
		.echo_wr (echo_r),
		.mix     (mix_r)
	);

endmodule
`default_nettype wire

FILE: tb/stereo_feedback_reverb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_feedback_reverb_checker
// Passive scoreboard for the stereo feedback reverb. It snoops the register
// channel and both streams. For every accepted input beat it runs its own
// fixed-point copy of the two delay lines, tap sums, feedback write-back and
// output mix, then queues the expected mix beat. Each output beat is compared
// field by field with the oldest queued beat.
// ----------------------------------------------------------------------------
package sfr_tb_pkg;
	import sfr_pkg::*;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TAP_A,
		REG_TAP_B,
		REG_TAP_C,
		REG_WET_GAIN
	} sfr_reg_t;
endpackage

module stereo_feedback_reverb_checker
	import sfr_pkg::*;
	import sfr_tb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [4*SMP_W-1:0]    s_tdata,
	input  logic                  s_tlast,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [2*SMP_W-1:0]    m_tdata,
	input  logic                  m_tlast,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    pending,
	output int                    errors
);

	typedef struct packed {
		logic signed [SMP_W-1:0] left;
		logic signed [SMP_W-1:0] right;
		logic                    last;
	} mix_beat_t;

	localparam longint ECHO_MAX = (longint'(1) <<< (ECHO_W - 1)) - 1;
	localparam longint ECHO_MIN = -(longint'(1) <<< (ECHO_W - 1));
	localparam longint MIX_MAX  = (longint'(1) <<< (SMP_W - 1)) - 1;
	localparam longint MIX_MIN  = -(longint'(1) <<< (SMP_W - 1));

	logic signed [ECHO_W-1:0] echo_l [SFR_DELAY_DEPTH];
	logic signed [ECHO_W-1:0] echo_r [SFR_DELAY_DEPTH];
	logic [DLY_W-1:0]         wr_ptr;
	logic [DLY_W-1:0]         dly_a;
	logic [DLY_W-1:0]         dly_b;
	logic [DLY_W-1:0]         dly_c;
	logic [GAIN_W-1:0]        gain;
	mix_beat_t                mix_due [$];

	initial begin
		pending = 0;
		errors  = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	function automatic longint round_half_up(input longint v, input int sh);
		return (v + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// a delay of zero reads one frame back; the 15-bit pointer wraps by itself
	function automatic logic [DLY_W-1:0] tap_addr(input logic [DLY_W-1:0] dly);
		return wr_ptr - ((dly == '0) ? DLY_W'(1) : dly);
	endfunction

	task automatic predict_frame(input logic [4*SMP_W-1:0] d, input logic last);
		logic [DLY_W-1:0] ia;
		logic [DLY_W-1:0] ib;
		logic [DLY_W-1:0] ic;
		longint           acc_l;
		longint           acc_r;
		longint           fb_l;
		longint           fb_r;
		mix_beat_t        beat;
		ia = tap_addr(dly_a);
		ib = tap_addr(dly_b);
		ic = tap_addr(dly_c);
		acc_l = longint'(echo_l[ia]) * longint'(COEF_A)
		      + longint'(echo_l[ib]) * longint'(COEF_B)
		      + longint'(echo_r[ic]) * longint'(COEF_C);
		acc_r = longint'(echo_r[ia]) * longint'(COEF_A)
		      + longint'(echo_r[ib]) * longint'(COEF_B)
		      + longint'(echo_l[ic]) * longint'(COEF_C);
		fb_l = longint'($signed(d[SMP_W-1:0]))
		     + round_half_up(acc_l * longint'(COEF_FB), FB_SH);
		fb_r = longint'($signed(d[2*SMP_W-1:SMP_W]))
		     + round_half_up(acc_r * longint'(COEF_FB), FB_SH);
		echo_l[wr_ptr] = ECHO_W'(clip(fb_l, ECHO_MIN, ECHO_MAX));
		echo_r[wr_ptr] = ECHO_W'(clip(fb_r, ECHO_MIN, ECHO_MAX));
		wr_ptr = wr_ptr + 1'b1;
		beat.left = SMP_W'(clip(longint'($signed(d[3*SMP_W-1:2*SMP_W]))
			+ round_half_up(acc_l * longint'(gain), MIX_SH), MIX_MIN, MIX_MAX));
		beat.right = SMP_W'(clip(longint'($signed(d[4*SMP_W-1:3*SMP_W]))
			+ round_half_up(acc_r * longint'(gain), MIX_SH), MIX_MIN, MIX_MAX));
		beat.last = last;
		mix_due.push_back(beat);
	endtask

	task automatic check_beat;
		mix_beat_t want;
		if (mix_due.size() == 0) begin
			report_mismatch("output beat with no frame outstanding");
		end else begin
			want = mix_due.pop_front();
			if ($signed(m_tdata[SMP_W-1:0]) != want.left)
				report_mismatch($sformatf("mix_left got %0d want %0d",
					$signed(m_tdata[SMP_W-1:0]), want.left));
			if ($signed(m_tdata[2*SMP_W-1:SMP_W]) != want.right)
				report_mismatch($sformatf("mix_right got %0d want %0d",
					$signed(m_tdata[2*SMP_W-1:SMP_W]), want.right));
			if (m_tlast != want.last)
				report_mismatch($sformatf("block_end_out got %0b want %0b",
					m_tlast, want.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly_a  = TAP_A_RESET;
			dly_b  = TAP_B_RESET;
			dly_c  = TAP_C_RESET;
			gain   = WET_GAIN_RESET;
			wr_ptr = '0;
			mix_due.delete();
			foreach (echo_l[i]) begin
				echo_l[i] = '0;
				echo_r[i] = '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TAP_A:    dly_a = cfg_data[DLY_W-1:0];
					REG_TAP_B:    dly_b = cfg_data[DLY_W-1:0];
					REG_TAP_C:    dly_c = cfg_data[DLY_W-1:0];
					REG_WET_GAIN: gain  = cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predict_frame(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				check_beat();
		end
		pending = mix_due.size();
	end

endmodule

FILE: tb/stereo_feedback_reverb_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_feedback_reverb_tb
// Stimulus and verdict for the stereo feedback reverb. A directed opening hits
// send and dry extremes, feedback and output saturation, zero and maximum
// delays and gains and ignored register indexes; random phases then reprogram
// the taps and gain while idle and stream frames with random stalls on one or
// both sides. Prediction and comparison live in the checker beside the block.
// ----------------------------------------------------------------------------
module stereo_feedback_reverb_tb;
	import sfr_pkg::*;
	import sfr_tb_pkg::*;

	localparam int unsigned RUN_LIMIT    = 600000;
	localparam int          TAIL         = 16;
	localparam int          PHASES       = 8;
	localparam int          PHASE_FRAMES = 135;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_WET_GAIN + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [4*SMP_W-1:0]    s_tdata   = '0;
	logic                  s_tlast   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [2*SMP_W-1:0]    m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int          pending;
	int          errors;
	int unsigned cycles     = 0;
	int unsigned rx_hold    = 0;
	logic        rx_busy    = 1'b1;
	logic        tx_calm    = 1'b0;
	int          frames_sent = 0;
	int          reg_writes  = 0;
	int          settings    = 1;

	stereo_feedback_reverb i_dut (.*);

	stereo_feedback_reverb_checker i_checker (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RUN_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// hold off the result stream in random bursts
	always @(negedge clk) begin
		if (rx_hold != 0) begin
			m_tready <= 1'b0;
			rx_hold  <= rx_hold - 1;
		end else begin
			m_tready <= 1'b1;
			if (rx_busy && $urandom_range(0, 99) < 30)
				rx_hold <= idle_len();
		end
	end

	function automatic logic [4*SMP_W-1:0] frame_bits(input int sl, input int sr,
		input int dl, input int dr);
		return {dr, dl, sr, sl};
	endfunction

	function automatic int rand_send();
		int unsigned r;
		logic [31:0] v;
		r = $urandom_range(0, 99);
		v = $urandom;
		if (r < 70)
			return int'({{8{v[23]}}, v[23:0]});
		if (r < 85)
			return int'(v);
		case ($urandom_range(0, 5))
			0:       return 32'sd8388607;
			1:       return 32'sd8388608;
			2:       return -32'sd8388608;
			3:       return -32'sd8388609;
			4:       return 32'h7FFF_FFFF;
			default: return 32'h8000_0000;
		endcase
	endfunction

	function automatic int rand_dry();
		int unsigned r;
		logic [31:0] v;
		r = $urandom_range(0, 99);
		v = $urandom;
		if (r < 55)
			return int'(v);
		if (r < 80)
			return int'({v[31], {15{~v[31]}}, v[15:0]});
		return int'({{12{v[19]}}, v[19:0]});
	endfunction

	function automatic logic [DLY_W-1:0] pick_delay();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return '0;
		if (r < 22)
			return DLY_W'(1);
		if (r < 30)
			return '1;
		if (r < 75)
			return DLY_W'($urandom_range(1, 64));
		return DLY_W'($urandom_range(65, 1100));
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		if (r < 30)
			return '1;
		if (r < 45)
			return GAIN_W'(16'h8000);
		return GAIN_W'($urandom);
	endfunction

	// leaves the frame on the bus at the negedge after acceptance
	task automatic push_frame(input logic [4*SMP_W-1:0] data, input logic last);
		int unsigned idle;
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		frames_sent++;
		idle = tx_calm ? 0 : idle_len();
		if (idle != 0) begin
			s_tvalid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (TAIL) @(negedge clk);
	endtask

	// leaves cfg_valid high; the caller drops it after the last beat
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		reg_writes++;
	endtask

	task automatic program_regs(input logic [DLY_W-1:0] a, input logic [DLY_W-1:0] b,
		input logic [DLY_W-1:0] c, input logic [GAIN_W-1:0] g, input logic spare);
		write_reg(REG_TAP_A, {1'($urandom_range(0, 1)), a});
		write_reg(REG_TAP_B, {1'($urandom_range(0, 1)), b});
		write_reg(REG_TAP_C, {1'($urandom_range(0, 1)), c});
		write_reg(REG_WET_GAIN, g);
		if (spare)
			write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
				CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int ph;
		int k;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: zero gain, dry passes straight through
		push_frame(frame_bits(1000, -1000, 32'h7FFF_FFFF, 32'h8000_0000), 1'b0);
		push_frame(frame_bits(-5, 7, 0, -1), 1'b1);
		drain();

		// shortest taps, zero delay on the cross tap, full gain, writes to spare indexes
		write_reg(REG_UNUSED_LO, '1);
		write_reg(REG_UNUSED_HI, '1);
		program_regs(DLY_W'(1), DLY_W'(2), '0, '1, 1'b0);
		settings++;
		push_frame(frame_bits(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0), 1'b0);
		push_frame(frame_bits(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b1);
		push_frame(frame_bits(8388607, -8388608, 0, 0), 1'b0);
		push_frame(frame_bits(32'h8000_0000, 32'h8000_0000, 0, 0), 1'b0);
		push_frame(frame_bits(0, 0, 32'h8000_0000, 32'h8000_0000), 1'b1);
		push_frame(frame_bits(-8388609, 8388608, 5, -5), 1'b0);
		push_frame(frame_bits(8388607, 0, 32'h7FFF_0000, 32'h8000_FFFF), 1'b0);
		repeat (4) push_frame(frame_bits(0, 0, 0, 0), 1'($urandom_range(0, 1)));
		drain();

		// longest taps reach back into never-written, cleared entries
		program_regs('1, '1, '1, GAIN_W'(16'h8000), 1'b0);
		settings++;
		push_frame(frame_bits(-1, 1, -1, 1), 1'b0);
		push_frame(frame_bits(4194304, -4194304, 0, 0), 1'b1);
		drain();

		program_regs('0, '0, '0, '0, 1'b0);
		settings++;
		repeat (3) push_frame(frame_bits(8388607, -8388608, 123, -123), 1'b0);

		for (ph = 0; ph < PHASES; ph++) begin
			drain();
			tx_calm = (ph % 3 == 0);
			rx_busy <= (ph % 3 != 1);
			program_regs(pick_delay(), pick_delay(), pick_delay(), pick_gain(),
				1'($urandom_range(0, 2) == 0));
			settings++;
			for (k = 0; k < PHASE_FRAMES; k++) begin
				if (ph == 4 && k == PHASE_FRAMES / 2)
					drain();
				push_frame(frame_bits(rand_send(), rand_send(), rand_dry(), rand_dry()),
					1'($urandom_range(0, 7) == 0));
			end
		end

		drain();
		$display("Covered %0d frames under %0d register settings (%0d register writes),",
			frames_sent, settings, reg_writes);
		$display("with delays from zero to 32767, gains from zero to full and random stalls.");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
